/* rtl/dccq_pkg.sv */
`timescale 1ns / 1ps
// Shared types for the dedup/cancel request queue: request and response
// payloads, slot layout, operation and status codes, controller states.
// No dependencies.
package dccq_pkg;

	localparam int TERM_W  = 8;
	localparam int COUNT_W = 3;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_FINISH = 2'd1,
		KIND_CANCEL = 2'd2,
		KIND_RESET  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_DUP   = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_APPEND,
		S_HEAD_RD,
		S_HEAD_CHK,
		S_DONE
	} state_t;

	// one incoming request
	typedef struct packed {
		kind_t             kind;
		logic [TERM_W-1:0] from_terminal;
		logic [TERM_W-1:0] to_terminal;
	} req_t;

	// one response
	typedef struct packed {
		status_t            status;
		logic               head_valid;
		logic [TERM_W-1:0]  head_from;
		logic [TERM_W-1:0]  head_to;
		logic               head_cancelled;
		logic [COUNT_W-1:0] entry_count;
	} rsp_t;

	// one queue slot as stored in memory
	typedef struct packed {
		logic [TERM_W-1:0] start_term;
		logic [TERM_W-1:0] end_term;
		logic              cancelled;
	} slot_t;

endpackage

/* rtl/dedup_cancel_request_queue.sv */
`timescale 1ns / 1ps
// Dedup/cancel request queue, top level. One request at a time.
// A cancel, or an add to a queue that is not full, scans the queued entries;
// an add with no duplicate writes the tail. The head is then read unless the
// queue is empty, and a finish pops each cancelled head it meets. A request
// is taken only once the last is done; the response register frees the core.
// Reset: arst_n empties the queue; slot memory contents are not cleared.
module dedup_cancel_request_queue #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  dccq_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output dccq_pkg::rsp_t  rsp
);
	import dccq_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	slot_t         rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	slot_t         wr_data;
	logic          res_valid;
	logic          res_ready;
	rsp_t          res;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	dccq_mem #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	dccq_ctrl #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.AW          (AW),
		.CW          (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	// response register
	assign res_ready = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* rtl/dccq_mem.sv */
`timescale 1ns / 1ps
// Slot memory: one write port, one read port, registered read data.
// Depends on dccq_pkg.
module dccq_mem #(
	parameter int DEPTH = 4,
	parameter int AW    = 2
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output dccq_pkg::slot_t  rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  dccq_pkg::slot_t  wr_data
);
	import dccq_pkg::*;

	slot_t mem_q [DEPTH];
	slot_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, registered output
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* rtl/dccq_ctrl.sv */
`timescale 1ns / 1ps
// Queue controller: head/occupancy registers and the sequencer that scans,
// appends, cancels and pops through the slot memory. Depends on dccq_pkg.
module dccq_ctrl #(
	parameter int QUEUE_DEPTH = 4,
	parameter int AW          = 2,
	parameter int CW          = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	// request side
	input  logic             req_valid,
	output logic             req_stall,
	input  dccq_pkg::req_t   req,
	// response toward the output register
	output logic             res_valid,
	input  logic             res_ready,
	output dccq_pkg::rsp_t   res,
	// slot memory
	output logic             rd_en,
	output logic [AW-1:0]    rd_addr,
	input  dccq_pkg::slot_t  rd_data,
	output logic             wr_en,
	output logic [AW-1:0]    wr_addr,
	output dccq_pkg::slot_t  wr_data
);
	import dccq_pkg::*;

	localparam int            AW1       = AW + 1;
	localparam logic [AW:0]   DEPTH_S   = AW1'(QUEUE_DEPTH);
	localparam logic [AW-1:0] HEAD_LAST = AW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] OCC_FULL  = CW'(QUEUE_DEPTH);

	// physical slot of an offset from a base, modulo the depth
	function automatic logic [AW-1:0] slot_at(input logic [AW-1:0] base,
	                                          input logic [AW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= DEPTH_S) begin
			sum = sum - DEPTH_S;
		end
		return sum[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
		return (idx == HEAD_LAST) ? '0 : idx + AW'(1);
	endfunction

	// control state
	state_t        state_q, state_d;
	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] occ_q, occ_d;
	logic [CW-1:0] k_q, k_d;
	logic          chk_s1, chk_d;
	logic          dup_q, dup_d;

	// request and result payload
	kind_t             kind_q, kind_d;
	logic [TERM_W-1:0] from_q, from_d;
	logic [TERM_W-1:0] to_q, to_d;
	status_t           status_q, status_d;
	logic [AW-1:0]     addr_s1, addr_d;
	logic              hval_q, hval_d;
	logic [TERM_W-1:0] hfrom_q, hfrom_d;
	logic [TERM_W-1:0] hto_q, hto_d;
	logic              hcan_q, hcan_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			occ_q   <= '0;
			k_q     <= '0;
			chk_s1  <= 1'b0;
			dup_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			occ_q   <= occ_d;
			k_q     <= k_d;
			chk_s1  <= chk_d;
			dup_q   <= dup_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q   <= kind_d;
		from_q   <= from_d;
		to_q     <= to_d;
		status_q <= status_d;
		addr_s1  <= addr_d;
		hval_q   <= hval_d;
		hfrom_q  <= hfrom_d;
		hto_q    <= hto_d;
		hcan_q   <= hcan_d;
	end

	// sequencer: next state, memory accesses, result capture
	always_comb begin
		state_d  = state_q;
		head_d   = head_q;
		occ_d    = occ_q;
		k_d      = k_q;
		chk_d    = 1'b0;
		dup_d    = dup_q;
		kind_d   = kind_q;
		from_d   = from_q;
		to_d     = to_q;
		status_d = status_q;
		addr_d   = addr_s1;
		hval_d   = hval_q;
		hfrom_d  = hfrom_q;
		hto_d    = hto_q;
		hcan_d   = hcan_q;
		req_stall = 1'b1;
		res_valid = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = head_q;
		wr_en    = 1'b0;
		wr_addr  = addr_s1;
		wr_data  = rd_data;

		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					kind_d   = req.kind;
					from_d   = req.from_terminal;
					to_d     = req.to_terminal;
					status_d = ST_OK;
					k_d      = '0;
					dup_d    = 1'b0;
					case (req.kind)
						KIND_ADD: begin
							if (occ_q == OCC_FULL) begin
								status_d = ST_FULL;
								state_d  = S_HEAD_RD;
							end else begin
								state_d = S_SCAN;
							end
						end
						KIND_FINISH: begin
							if (occ_q == '0) begin
								status_d = ST_EMPTY;
							end else begin
								head_d = next_slot(head_q);
								occ_d  = occ_q - CW'(1);
							end
							state_d = S_HEAD_RD;
						end
						KIND_CANCEL: begin
							state_d = S_SCAN;
						end
						KIND_RESET: begin
							head_d  = '0;
							occ_d   = '0;
							state_d = S_HEAD_RD;
						end
						default: begin
							state_d = S_HEAD_RD;
						end
					endcase
				end
			end

			// pipelined scan: issue one read a cycle, check the one before
			S_SCAN: begin
				if (chk_s1 && rd_data.start_term == from_q) begin
					if (kind_q == KIND_CANCEL) begin
						wr_en             = 1'b1;
						wr_addr           = addr_s1;
						wr_data           = rd_data;
						wr_data.cancelled = 1'b1;
					end else if (!rd_data.cancelled) begin
						dup_d = 1'b1;
					end
				end
				if (k_q != occ_q) begin
					rd_en   = 1'b1;
					rd_addr = slot_at(head_q, k_q[AW-1:0]);
					addr_d  = rd_addr;
					chk_d   = 1'b1;
					k_d     = k_q + CW'(1);
				end else if (!chk_s1) begin
					if (kind_q == KIND_ADD) begin
						if (dup_q) begin
							status_d = ST_DUP;
							state_d  = S_HEAD_RD;
						end else begin
							state_d = S_APPEND;
						end
					end else begin
						state_d = S_HEAD_RD;
					end
				end
			end

			// write the new request at the tail
			S_APPEND: begin
				wr_en   = 1'b1;
				wr_addr = slot_at(head_q, occ_q[AW-1:0]);
				wr_data = '{start_term: from_q, end_term: to_q, cancelled: 1'b0};
				occ_d   = occ_q + CW'(1);
				state_d = S_HEAD_RD;
			end

			S_HEAD_RD: begin
				if (occ_q == '0) begin
					hval_d  = 1'b0;
					hfrom_d = '0;
					hto_d   = '0;
					hcan_d  = 1'b0;
					state_d = S_DONE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = head_q;
					state_d = S_HEAD_CHK;
				end
			end

			// a finish keeps popping cancelled heads
			S_HEAD_CHK: begin
				if (kind_q == KIND_FINISH && rd_data.cancelled) begin
					head_d  = next_slot(head_q);
					occ_d   = occ_q - CW'(1);
					state_d = S_HEAD_RD;
				end else begin
					hval_d  = 1'b1;
					hfrom_d = rd_data.start_term;
					hto_d   = rd_data.end_term;
					hcan_d  = rd_data.cancelled;
					state_d = S_DONE;
				end
			end

			S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// response fields
	always_comb begin
		res.status         = status_q;
		res.head_valid     = hval_q;
		res.head_from      = hfrom_q;
		res.head_to        = hto_q;
		res.head_cancelled = hcan_q;
		res.entry_count    = COUNT_W'(occ_q);
	end

endmodule
